// ===== design/fea_pkg.sv =====
// Package for the free extent allocator: sequencer states, status codes,
// placement policy codes, action codes and field widths. Used by the interfaces and the top level.
`default_nettype none
package fea_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SHIFT,
      ST_WRITE,
      ST_FINISH
   } state_type;

   localparam int STATUS_BITS = 3;
   typedef logic [STATUS_BITS-1:0] status_type;

   localparam status_type STATUS_OK      = 3'd0;
   localparam status_type STATUS_NOFIT   = 3'd1;
   localparam status_type STATUS_FULL    = 3'd2;
   localparam status_type STATUS_OVERLAP = 3'd3;
   localparam status_type STATUS_ZERO    = 3'd4;

   typedef logic [1:0] policy_type;

   localparam policy_type POLICY_FIRST = 2'd0;
   localparam policy_type POLICY_BEST  = 2'd1;
   localparam policy_type POLICY_NEXT  = 2'd2;

   localparam int ACTION_ALLOC = 0;
   localparam int ACTION_FREE  = 1;

   localparam int FIELD_BITS = 32;
   localparam int FREE_BITS  = 6;

endpackage
`default_nettype wire

// ===== design/fea_req_if.sv =====
// Request channel of the free extent allocator: valid/ready and one word.
// Depends on fea_pkg for the field width.
`default_nettype none
interface fea_req_if;
   logic                           valid;
   logic                           ready;
   logic                           action;
   logic [fea_pkg::FIELD_BITS-1:0] block_start;
   logic [fea_pkg::FIELD_BITS-1:0] block_size;

   modport source (output valid, output action, output block_start, output block_size,
                   input ready);
   modport sink   (input valid, input action, input block_start, input block_size,
                   output ready);
endinterface
`default_nettype wire

// ===== design/fea_rsp_if.sv =====
// Response channel of the free extent allocator: valid/ready and one word.
// Depends on fea_pkg for the field types.
`default_nettype none
interface fea_rsp_if;
   logic                           valid;
   logic                           ready;
   fea_pkg::status_type            status;
   logic [fea_pkg::FIELD_BITS-1:0] granted_start;
   logic [fea_pkg::FREE_BITS-1:0]  free_entries;

   modport source (output valid, output status, output granted_start, output free_entries,
                   input ready);
   modport sink   (input valid, input status, input granted_start, input free_entries,
                   output ready);
endinterface
`default_nettype wire

// ===== design/free_extent_allocator.sv =====
// Free extent allocator top level: extent table memory, scan and shift sequencer.
// Depends on fea_pkg, fea_req_if and fea_rsp_if.
//
// Usage:
//   req_chan carries one word per request: action (0 allocate, 1 free),
//   block_start (free only) and block_size. rsp_chan returns one word per
//   request: status, granted_start and free_entries.
//   csr_wr_en/csr_wr_data write the placement policy; write it only when idle.
// Timing:
//   One request at a time. The table sits in a single-port-read memory with
//   a registered read, so a request walks the N held extents at one per
//   cycle, then moves one entry per cycle when an extent is removed or
//   inserted (fewer than N entries), then writes the changed entry and
//   sends the response. Zero size and out-of-range frees skip the scan and
//   go straight to the response.
// Reset:
//   Table empty, policy first fit, no next-fit rover. No clearing pass.
// Stall:
//   The response sits in an output register; the next request is taken while
//   it waits, and is held in its last step until the register frees up.
`default_nettype none
module free_extent_allocator #(
   parameter int MAX_EXTENTS = 32,
   parameter int ADDR_BITS   = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   fea_req_if.sink          req_chan,
   fea_rsp_if.source        rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_wr_data
);

   localparam int AW   = ADDR_BITS;
   localparam int XW   = ((ADDR_BITS > fea_pkg::FIELD_BITS) ? ADDR_BITS
                                                             : fea_pkg::FIELD_BITS) + 2;
   localparam int IW   = $clog2(MAX_EXTENTS);
   localparam int CNTW = $clog2(MAX_EXTENTS + 1);

   localparam logic [XW-1:0] MASK_X = {{(XW-AW){1'b0}}, {AW{1'b1}}};

   // extent table: {start, length}
   logic [2*AW-1:0] ext_mem [MAX_EXTENTS];
   logic [2*AW-1:0] rd_data_ff;
   logic [IW-1:0]   rd_addr;
   logic            mem_we;
   logic [IW-1:0]   mem_wa;
   logic [2*AW-1:0] mem_wd;

   fea_pkg::state_type  state_ff, state_in;
   fea_pkg::policy_type policy_ff;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic [AW-1:0]       rover_ff, rover_in;
   logic                rover_v_ff, rover_v_in;

   logic                act_ff, act_in;
   logic [AW-1:0]       s_ff, s_in;
   logic [AW-1:0]       last_ff, last_in;
   logic [XW-1:0]       size_ff, size_in;

   logic [CNTW-1:0]     rd_idx_ff, rd_idx_in;
   logic                ev_v_ff, ev_v_in;
   logic [IW-1:0]       ev_idx_ff, ev_idx_in;

   logic                a_found_ff, a_found_in, b_found_ff, b_found_in;
   logic [IW-1:0]       a_idx_ff, a_idx_in, b_idx_ff, b_idx_in;
   logic [AW-1:0]       a_start_ff, a_start_in, b_start_ff, b_start_in;
   logic [AW-1:0]       a_len_ff, a_len_in, b_len_ff, b_len_in;
   logic                ovl_ff, ovl_in;

   logic                sh_up_ff, sh_up_in;
   logic [CNTW-1:0]     sh_idx_ff, sh_idx_in;
   logic [CNTW-1:0]     sh_rem_ff, sh_rem_in;
   logic                sh_wv_ff, sh_wv_in;
   logic [IW-1:0]       sh_dst_ff, sh_dst_in;

   logic                wr_pend_ff, wr_pend_in;
   logic [IW-1:0]       wr_addr_ff, wr_addr_in;
   logic [2*AW-1:0]     wr_data_ff, wr_data_in;

   fea_pkg::status_type status_ff, status_in;
   logic [AW-1:0]       grant_ff, grant_in;

   logic                         rsp_v_ff, rsp_v_in;
   fea_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [fea_pkg::FIELD_BITS-1:0] rsp_grant_ff, rsp_grant_in;
   logic [fea_pkg::FREE_BITS-1:0]  rsp_free_ff, rsp_free_in;

   // handshake and common terms
   logic req_acc, slot_free, nf_mode;
   logic [XW-1:0] in_s_x, in_size_x;
   logic          in_range_bad;

   // entry under evaluation
   logic [AW-1:0] e_start, e_len, e_last;
   logic [XW-1:0] e_len_x;

   // decision
   fea_pkg::status_type dec_status;
   logic [CNTW-1:0]     dec_cnt, dec_rem, dec_sidx;
   logic                dec_up, dec_wr, dec_rover;
   logic [IW-1:0]       dec_wa;
   logic [2*AW-1:0]     dec_wd;
   logic [AW-1:0]       dec_grant;

   assign req_acc   = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_v_ff || rsp_chan.ready;
   assign nf_mode   = (policy_ff == fea_pkg::POLICY_NEXT) && rover_v_ff;

   assign in_s_x       = XW'(req_chan.block_start);
   assign in_size_x    = XW'(req_chan.block_size);
   assign in_range_bad = (in_s_x > MASK_X) || ((in_size_x - XW'(1)) > (MASK_X - in_s_x));

   assign e_start = rd_data_ff[2*AW-1:AW];
   assign e_len   = rd_data_ff[AW-1:0];
   assign e_last  = e_start + e_len - AW'(1);
   assign e_len_x = XW'(e_len);

   assign req_chan.ready       = (state_ff == fea_pkg::ST_IDLE);
   assign rsp_chan.valid        = rsp_v_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.granted_start = rsp_grant_ff;
   assign rsp_chan.free_entries = rsp_free_ff;

   // outcome of a finished scan
   always_comb begin
      logic [IW-1:0]   c_idx;
      logic [AW-1:0]   c_start, c_len;
      logic [CNTW-1:0] p_cnt;
      logic            prev_adj, next_adj;
      logic [XW-1:0]   sp, sn, sb;
      dec_status = fea_pkg::STATUS_OK;
      dec_cnt    = cnt_ff;
      dec_rem    = '0;
      dec_sidx   = '0;
      dec_up     = 1'b0;
      dec_wr     = 1'b0;
      dec_wa     = '0;
      dec_wd     = '0;
      dec_grant  = '0;
      dec_rover  = 1'b0;
      c_idx   = a_found_ff ? a_idx_ff : b_idx_ff;
      c_start = a_found_ff ? a_start_ff : b_start_ff;
      c_len   = a_found_ff ? a_len_ff : b_len_ff;
      p_cnt    = a_found_ff ? CNTW'(a_idx_ff) : cnt_ff;
      prev_adj = b_found_ff && ((XW'(b_start_ff) + XW'(b_len_ff)) == XW'(s_ff));
      next_adj = a_found_ff && ((XW'(last_ff) + XW'(1)) == XW'(a_start_ff));
      sp = XW'(b_len_ff) + size_ff;
      sn = size_ff + XW'(a_len_ff);
      sb = sp + XW'(a_len_ff);
      if (act_ff == 1'(fea_pkg::ACTION_ALLOC)) begin
         if (!a_found_ff && !b_found_ff) begin
            dec_status = fea_pkg::STATUS_NOFIT;
         end else begin
            dec_grant = c_start;
            dec_rover = (policy_ff == fea_pkg::POLICY_NEXT);
            if (XW'(c_len) == size_ff) begin
               dec_rem  = cnt_ff - CNTW'(1) - CNTW'(c_idx);
               dec_sidx = CNTW'(c_idx) + CNTW'(1);
               dec_cnt  = cnt_ff - CNTW'(1);
            end else begin
               dec_wr = 1'b1;
               dec_wa = c_idx;
               dec_wd = {c_start + AW'(size_ff), c_len - AW'(size_ff)};
            end
         end
      end else if (ovl_ff) begin
         dec_status = fea_pkg::STATUS_OVERLAP;
      end else if (prev_adj && next_adj) begin
         if (sb > MASK_X) begin
            dec_status = fea_pkg::STATUS_OVERLAP;
         end else begin
            dec_wr   = 1'b1;
            dec_wa   = b_idx_ff;
            dec_wd   = {b_start_ff, AW'(sb)};
            dec_rem  = cnt_ff - CNTW'(1) - CNTW'(a_idx_ff);
            dec_sidx = CNTW'(a_idx_ff) + CNTW'(1);
            dec_cnt  = cnt_ff - CNTW'(1);
         end
      end else if (prev_adj) begin
         if (sp > MASK_X) begin
            dec_status = fea_pkg::STATUS_OVERLAP;
         end else begin
            dec_wr = 1'b1;
            dec_wa = b_idx_ff;
            dec_wd = {b_start_ff, AW'(sp)};
         end
      end else if (next_adj) begin
         if (sn > MASK_X) begin
            dec_status = fea_pkg::STATUS_OVERLAP;
         end else begin
            dec_wr = 1'b1;
            dec_wa = a_idx_ff;
            dec_wd = {s_ff, AW'(sn)};
         end
      end else if (cnt_ff >= CNTW'(MAX_EXTENTS)) begin
         dec_status = fea_pkg::STATUS_FULL;
      end else begin
         // open a slot at p by moving the tail up one place
         dec_up   = 1'b1;
         dec_rem  = cnt_ff - p_cnt;
         dec_sidx = cnt_ff - CNTW'(1);
         dec_wr   = 1'b1;
         dec_wa   = IW'(p_cnt);
         dec_wd   = {s_ff, AW'(size_ff)};
         dec_cnt  = cnt_ff + CNTW'(1);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fea_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_chan.block_size == '0 ||
                   (req_chan.action == 1'(fea_pkg::ACTION_FREE) && in_range_bad)) begin
                  state_in = fea_pkg::ST_FINISH;
               end else begin
                  state_in = fea_pkg::ST_SCAN;
               end
            end
         end
         fea_pkg::ST_SCAN: begin
            if (rd_idx_ff == cnt_ff && !ev_v_ff) begin
               state_in = fea_pkg::ST_DECIDE;
            end
         end
         fea_pkg::ST_DECIDE: begin
            if (dec_status != fea_pkg::STATUS_OK) begin
               state_in = fea_pkg::ST_FINISH;
            end else if (dec_rem != '0) begin
               state_in = fea_pkg::ST_SHIFT;
            end else if (dec_wr) begin
               state_in = fea_pkg::ST_WRITE;
            end else begin
               state_in = fea_pkg::ST_FINISH;
            end
         end
         fea_pkg::ST_SHIFT: begin
            if (sh_rem_ff == '0 && !sh_wv_ff) begin
               state_in = wr_pend_ff ? fea_pkg::ST_WRITE : fea_pkg::ST_FINISH;
            end
         end
         fea_pkg::ST_WRITE: begin
            state_in = fea_pkg::ST_FINISH;
         end
         fea_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = fea_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fea_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      cnt_in     = cnt_ff;
      rover_in   = rover_ff;
      rover_v_in = rover_v_ff;
      act_in     = act_ff;
      s_in       = s_ff;
      last_in    = last_ff;
      size_in    = size_ff;
      rd_idx_in  = rd_idx_ff;
      ev_v_in    = 1'b0;
      ev_idx_in  = ev_idx_ff;
      a_found_in = a_found_ff;
      a_idx_in   = a_idx_ff;
      a_start_in = a_start_ff;
      a_len_in   = a_len_ff;
      b_found_in = b_found_ff;
      b_idx_in   = b_idx_ff;
      b_start_in = b_start_ff;
      b_len_in   = b_len_ff;
      ovl_in     = ovl_ff;
      sh_up_in   = sh_up_ff;
      sh_idx_in  = sh_idx_ff;
      sh_rem_in  = sh_rem_ff;
      sh_wv_in   = 1'b0;
      sh_dst_in  = sh_dst_ff;
      wr_pend_in = wr_pend_ff;
      wr_addr_in = wr_addr_ff;
      wr_data_in = wr_data_ff;
      status_in  = status_ff;
      grant_in   = grant_ff;
      rd_addr    = rd_idx_ff[IW-1:0];
      mem_we     = 1'b0;
      mem_wa     = sh_dst_ff;
      mem_wd     = rd_data_ff;
      rsp_v_in      = rsp_v_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_grant_in  = rsp_grant_ff;
      rsp_free_in   = rsp_free_ff;

      unique case (state_ff)
         fea_pkg::ST_IDLE: begin
            act_in     = req_chan.action;
            s_in       = AW'(in_s_x);
            last_in    = AW'(in_s_x + in_size_x - XW'(1));
            size_in    = in_size_x;
            rd_idx_in  = '0;
            a_found_in = 1'b0;
            b_found_in = 1'b0;
            ovl_in     = 1'b0;
            grant_in   = '0;
            status_in  = fea_pkg::STATUS_OK;
            if (req_chan.block_size == '0) begin
               status_in = fea_pkg::STATUS_ZERO;
            end else if (req_chan.action == 1'(fea_pkg::ACTION_FREE) && in_range_bad) begin
               status_in = fea_pkg::STATUS_OVERLAP;
            end
         end
         fea_pkg::ST_SCAN: begin
            if (rd_idx_ff != cnt_ff) begin
               rd_idx_in = rd_idx_ff + CNTW'(1);
               ev_v_in   = 1'b1;
               ev_idx_in = rd_idx_ff[IW-1:0];
            end
            if (ev_v_ff) begin
               if (act_ff == 1'(fea_pkg::ACTION_FREE)) begin
                  if (s_ff <= e_last && e_start <= last_ff) begin
                     ovl_in = 1'b1;
                  end
                  // a: first extent above the block; b: last one at or below it
                  if (!a_found_ff) begin
                     if (e_start > s_ff) begin
                        a_found_in = 1'b1;
                        a_idx_in   = ev_idx_ff;
                        a_start_in = e_start;
                        a_len_in   = e_len;
                     end else begin
                        b_found_in = 1'b1;
                        b_idx_in   = ev_idx_ff;
                        b_start_in = e_start;
                        b_len_in   = e_len;
                     end
                  end
               end else if (policy_ff == fea_pkg::POLICY_BEST) begin
                  // a: first exact size; b: smallest larger, last of equals
                  if (!a_found_ff && e_len_x == size_ff) begin
                     a_found_in = 1'b1;
                     a_idx_in   = ev_idx_ff;
                     a_start_in = e_start;
                     a_len_in   = e_len;
                  end
                  if (e_len_x > size_ff && (!b_found_ff || e_len <= b_len_ff)) begin
                     b_found_in = 1'b1;
                     b_idx_in   = ev_idx_ff;
                     b_start_in = e_start;
                     b_len_in   = e_len;
                  end
               end else if (nf_mode) begin
                  // a: first fit past the rover; b: first fit from the bottom
                  if (!a_found_ff && e_start > rover_ff && e_len_x >= size_ff) begin
                     a_found_in = 1'b1;
                     a_idx_in   = ev_idx_ff;
                     a_start_in = e_start;
                     a_len_in   = e_len;
                  end
                  if (!b_found_ff && e_start <= rover_ff && e_len_x >= size_ff) begin
                     b_found_in = 1'b1;
                     b_idx_in   = ev_idx_ff;
                     b_start_in = e_start;
                     b_len_in   = e_len;
                  end
               end else begin
                  if (!a_found_ff && e_len_x >= size_ff) begin
                     a_found_in = 1'b1;
                     a_idx_in   = ev_idx_ff;
                     a_start_in = e_start;
                     a_len_in   = e_len;
                  end
               end
            end
         end
         fea_pkg::ST_DECIDE: begin
            status_in  = dec_status;
            grant_in   = dec_grant;
            cnt_in     = dec_cnt;
            sh_up_in   = dec_up;
            sh_idx_in  = dec_sidx;
            sh_rem_in  = dec_rem;
            wr_pend_in = dec_wr;
            wr_addr_in = dec_wa;
            wr_data_in = dec_wd;
            if (dec_status == fea_pkg::STATUS_OK && dec_rover) begin
               rover_in   = dec_grant;
               rover_v_in = 1'b1;
            end
         end
         fea_pkg::ST_SHIFT: begin
            rd_addr = sh_idx_ff[IW-1:0];
            if (sh_rem_ff != '0) begin
               sh_wv_in  = 1'b1;
               sh_rem_in = sh_rem_ff - CNTW'(1);
               if (sh_up_ff) begin
                  sh_dst_in = IW'(sh_idx_ff + CNTW'(1));
                  sh_idx_in = sh_idx_ff - CNTW'(1);
               end else begin
                  sh_dst_in = IW'(sh_idx_ff - CNTW'(1));
                  sh_idx_in = sh_idx_ff + CNTW'(1);
               end
            end
            // write the entry read last cycle to its new place
            if (sh_wv_ff) begin
               mem_we = 1'b1;
            end
         end
         fea_pkg::ST_WRITE: begin
            mem_we = 1'b1;
            mem_wa = wr_addr_ff;
            mem_wd = wr_data_ff;
         end
         fea_pkg::ST_FINISH: begin
            if (slot_free) begin
               rsp_v_in      = 1'b1;
               rsp_status_in = status_ff;
               rsp_grant_in  = fea_pkg::FIELD_BITS'(grant_ff);
               rsp_free_in   = fea_pkg::FREE_BITS'(cnt_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ext_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= ext_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= fea_pkg::ST_IDLE;
         policy_ff  <= fea_pkg::POLICY_FIRST;
         cnt_ff     <= '0;
         rover_ff   <= '0;
         rover_v_ff <= 1'b0;
         ev_v_ff    <= 1'b0;
         sh_wv_ff   <= 1'b0;
         rsp_v_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         if (csr_wr_en) begin
            policy_ff <= csr_wr_data;
         end
         cnt_ff     <= cnt_in;
         rover_ff   <= rover_in;
         rover_v_ff <= rover_v_in;
         ev_v_ff    <= ev_v_in;
         sh_wv_ff   <= sh_wv_in;
         rsp_v_ff   <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      s_ff          <= s_in;
      last_ff       <= last_in;
      size_ff       <= size_in;
      rd_idx_ff     <= rd_idx_in;
      ev_idx_ff     <= ev_idx_in;
      a_found_ff    <= a_found_in;
      a_idx_ff      <= a_idx_in;
      a_start_ff    <= a_start_in;
      a_len_ff      <= a_len_in;
      b_found_ff    <= b_found_in;
      b_idx_ff      <= b_idx_in;
      b_start_ff    <= b_start_in;
      b_len_ff      <= b_len_in;
      ovl_ff        <= ovl_in;
      sh_up_ff      <= sh_up_in;
      sh_idx_ff     <= sh_idx_in;
      sh_rem_ff     <= sh_rem_in;
      sh_dst_ff     <= sh_dst_in;
      wr_pend_ff    <= wr_pend_in;
      wr_addr_ff    <= wr_addr_in;
      wr_data_ff    <= wr_data_in;
      status_ff     <= status_in;
      grant_ff      <= grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_free_ff   <= rsp_free_in;
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNTW'(MAX_EXTENTS))
      else $error("extent count above table depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff != fea_pkg::ST_IDLE)
      else $error("request accepted but sequencer stayed idle");

   a_free_matches: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_v_ff) |-> rsp_free_ff == fea_pkg::FREE_BITS'(cnt_ff))
      else $error("free_entries disagrees with extent count");

   a_scan_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fea_pkg::ST_SCAN && ev_v_ff) |-> CNTW'(ev_idx_ff) < cnt_ff)
      else $error("scan evaluated an entry beyond the table");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/free_extent_allocator_tb_if.sv =====
`timescale 1ns / 100ps
// Testbench-side note file: the channel interfaces come from the design tree
// (fea_req_if, fea_rsp_if); this file holds the scoreboard class used by the tb.
// Depends on fea_pkg.
`default_nettype none
package fea_tb_pkg;

   typedef struct packed {
      fea_pkg::status_type status;
      logic [31:0]         granted_start;
      logic [5:0]          free_entries;
   } rsp_word_type;

   class extent_scoreboard;
      logic [31:0]  ext_base[32];
      logic [31:0]  ext_len[32];
      int           ext_cnt;
      logic [31:0]  rover;
      bit           rover_set;
      logic [1:0]   policy;
      rsp_word_type pending[$];
      int           errors;
      int           checked;

      function void clear_table();
         ext_cnt = 0; rover = 0; rover_set = 0; policy = fea_pkg::POLICY_FIRST;
         pending.delete(); errors = 0; checked = 0;
      endfunction

      function void drop_entry(int i);
         for (int k = i; k < ext_cnt - 1; k++) begin
            ext_base[k] = ext_base[k+1];
            ext_len[k]  = ext_len[k+1];
         end
         ext_cnt--;
      endfunction

      function int pick_extent(logic [31:0] sz);
         logic [32:0] best;
         int pk;
         best = 33'h1_FFFF_FFFF;
         pk = -1;
         if (policy == fea_pkg::POLICY_BEST) begin
            for (int i = 0; i < ext_cnt; i++) begin
               if (ext_len[i] == sz) return i;
               if (ext_len[i] > sz && {1'b0, ext_len[i]} <= best) begin
                  best = {1'b0, ext_len[i]};
                  pk = i;
               end
            end
            return pk;
         end
         if (policy == fea_pkg::POLICY_NEXT && rover_set) begin
            for (int i = 0; i < ext_cnt; i++)
               if (ext_base[i] > rover && ext_len[i] >= sz) return i;
            for (int i = 0; i < ext_cnt; i++)
               if (ext_base[i] <= rover && ext_len[i] >= sz) return i;
            return -1;
         end
         for (int i = 0; i < ext_cnt; i++)
            if (ext_len[i] >= sz) return i;
         return -1;
      endfunction

      function fea_pkg::status_type release_block(logic [31:0] s, logic [31:0] sz);
         logic [32:0] last, alast, sum;
         int p;
         bit prev_adj, next_adj;
         if ({1'b0, s} + {1'b0, sz} - 33'd1 > 33'hFFFF_FFFF) return fea_pkg::STATUS_OVERLAP;
         last = {1'b0, s} + {1'b0, sz} - 33'd1;
         p = ext_cnt;
         for (int i = 0; i < ext_cnt; i++) begin
            alast = {1'b0, ext_base[i]} + {1'b0, ext_len[i]} - 33'd1;
            if ({1'b0, s} <= alast && {1'b0, ext_base[i]} <= last)
               return fea_pkg::STATUS_OVERLAP;
            if (p == ext_cnt && ext_base[i] > s) p = i;
         end
         prev_adj = 0; next_adj = 0;
         if (p > 0) begin
            alast = {1'b0, ext_base[p-1]} + {1'b0, ext_len[p-1]} - 33'd1;
            prev_adj = (s != 0) && (alast == {1'b0, s} - 33'd1);
         end
         if (p < ext_cnt)
            next_adj = (last != 33'hFFFF_FFFF) && (last + 33'd1 == {1'b0, ext_base[p]});
         if (prev_adj && next_adj) begin
            sum = {1'b0, ext_len[p-1]} + {1'b0, sz} + {1'b0, ext_len[p]};
            if (sum > 33'hFFFF_FFFF) return fea_pkg::STATUS_OVERLAP;
            ext_len[p-1] = sum[31:0];
            drop_entry(p);
         end else if (prev_adj) begin
            sum = {1'b0, ext_len[p-1]} + {1'b0, sz};
            if (sum > 33'hFFFF_FFFF) return fea_pkg::STATUS_OVERLAP;
            ext_len[p-1] = sum[31:0];
         end else if (next_adj) begin
            sum = {1'b0, ext_len[p]} + {1'b0, sz};
            if (sum > 33'hFFFF_FFFF) return fea_pkg::STATUS_OVERLAP;
            ext_base[p] = s;
            ext_len[p] = sum[31:0];
         end else begin
            if (ext_cnt >= 32) return fea_pkg::STATUS_FULL;
            for (int k = ext_cnt; k > p; k--) begin
               ext_base[k] = ext_base[k-1];
               ext_len[k]  = ext_len[k-1];
            end
            ext_base[p] = s;
            ext_len[p] = sz;
            ext_cnt++;
         end
         return fea_pkg::STATUS_OK;
      endfunction

      function void note_request(bit act, logic [31:0] s, logic [31:0] sz);
         rsp_word_type w;
         int pk;
         w.granted_start = 0;
         if (sz == 0) w.status = fea_pkg::STATUS_ZERO;
         else if (act == 1'(fea_pkg::ACTION_FREE)) w.status = release_block(s, sz);
         else begin
            pk = pick_extent(sz);
            if (pk < 0) w.status = fea_pkg::STATUS_NOFIT;
            else begin
               w.status = fea_pkg::STATUS_OK;
               w.granted_start = ext_base[pk];
               if (ext_len[pk] == sz) drop_entry(pk);
               else begin
                  ext_base[pk] += sz;
                  ext_len[pk]  -= sz;
               end
               if (policy == fea_pkg::POLICY_NEXT) begin
                  rover = w.granted_start;
                  rover_set = 1;
               end
            end
         end
         w.free_entries = ext_cnt[5:0];
         pending.push_back(w);
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type exp_w;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response word %p", got);
            return;
         end
         exp_w = pending.pop_front();
         if (got !== exp_w) begin
            errors++;
            if (errors <= 10)
               $display("mismatch #%0d: exp st=%0d gs=%h fe=%0d got st=%0d gs=%h fe=%0d",
                        checked, exp_w.status, exp_w.granted_start, exp_w.free_entries,
                        got.status, got.granted_start, got.free_entries);
         end
      endfunction
   endclass
endpackage
`default_nettype wire

// ===== tb/sv/free_extent_allocator_tb.sv =====
`timescale 1ns / 100ps
// Top-level testbench for free_extent_allocator: random alloc/free traffic under
// all fit policies, checked against an in-bench extent table. Uses fea_tb_pkg.
`default_nettype none
module free_extent_allocator_tb;

   logic       clock = 0;
   logic       reset = 1;
   logic       csr_wr_en = 0;
   logic [1:0] csr_wr_data = 0;
   bit         long_hold = 0;
   bit         fill_phase = 0;

   fea_req_if req_chan();
   fea_rsp_if rsp_chan();

   fea_tb_pkg::extent_scoreboard ledger = new();

   free_extent_allocator u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #4 clock = ~clock;

   initial begin
      req_chan.valid = 0;
      req_chan.action = 0;
      req_chan.block_start = 0;
      req_chan.block_size = 0;
      rsp_chan.ready = 0;
   end

   // receiver stall pattern; long hold-off counted here
   initial begin
      int hold;
      int phase;
      phase = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_chan.ready <= 0;
            for (hold = 0; hold < 400; hold++) @(posedge clock);
            long_hold = 0;
         end
         phase++;
         if ((phase / 300) % 3 == 0) rsp_chan.ready <= 1;
         else rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         ledger.check_response('{rsp_chan.status, rsp_chan.granted_start,
                                 rsp_chan.free_entries});

   task automatic send_word(bit act, logic [31:0] s, logic [31:0] sz);
      req_chan.valid       <= 1;
      req_chan.action      <= act;
      req_chan.block_start <= s;
      req_chan.block_size  <= sz;
      do @(posedge clock); while (!req_chan.ready);
      ledger.note_request(act, s, sz);
   endtask

   task automatic go_idle(int n);
      req_chan.valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_chan.valid <= 0;
      while (ledger.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_policy(logic [1:0] p);
      drain();
      csr_wr_en   <= 1;
      csr_wr_data <= p;
      @(posedge clock);
      csr_wr_en <= 0;
      ledger.policy = p;
      @(posedge clock);
   endtask

   // mostly well-formed: frees near held extents, modest sizes
   task automatic random_word();
      int r;
      int i;
      logic [31:0] s, sz;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         send_word(1'($urandom_range(0, 1)), $urandom, $urandom);
         return;
      end
      if (r < 5) begin
         send_word(1'($urandom_range(0, 1)), $urandom, 32'd0);
         return;
      end
      sz = (r < 8) ? $urandom : 32'($urandom_range(1, 64));
      if (r < 50 || ledger.ext_cnt == 0) begin
         if ($urandom_range(0, 9) == 0) s = $urandom;
         else s = 32'h1000 + 32'($urandom_range(0, 4095));
         if (ledger.ext_cnt != 0 && $urandom_range(0, 3) == 0) begin
            i = $urandom_range(0, ledger.ext_cnt - 1);
            s = ledger.ext_base[i] + ledger.ext_len[i] + 32'($urandom_range(0, 2));
         end
         send_word(1'(fea_pkg::ACTION_FREE), s, sz);
      end else
         send_word(1'(fea_pkg::ACTION_ALLOC), 32'd0, sz);
   endtask

   initial begin
      int burst;
      ledger.clear_table();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: zero sizes, extremes, overflow, no-fit, merges
      send_word(1'(fea_pkg::ACTION_ALLOC), 0, 0);
      send_word(1'(fea_pkg::ACTION_FREE), 32'h10, 0);
      send_word(1'(fea_pkg::ACTION_ALLOC), 0, 32'hFFFF_FFFF);
      send_word(1'(fea_pkg::ACTION_FREE), 32'hFFFF_FFFF, 2);
      send_word(1'(fea_pkg::ACTION_FREE), 32'hFFFF_FFFF, 1);
      send_word(1'(fea_pkg::ACTION_FREE), 0, 32'h100);
      send_word(1'(fea_pkg::ACTION_FREE), 32'h80, 4);
      send_word(1'(fea_pkg::ACTION_FREE), 32'h200, 32'h100);
      send_word(1'(fea_pkg::ACTION_FREE), 32'h100, 32'h100);
      send_word(1'(fea_pkg::ACTION_ALLOC), 0, 32'h300);
      send_word(1'(fea_pkg::ACTION_ALLOC), 0, 1);
      send_word(1'(fea_pkg::ACTION_FREE), 0, 1);
      send_word(1'(fea_pkg::ACTION_FREE), 1, 32'hFFFF_FFFE);
      send_word(1'(fea_pkg::ACTION_ALLOC), 0, 32'hFFFF_FFFF);
      send_word(1'(fea_pkg::ACTION_FREE), 5, 32'hFFFF_FFFA);
      send_word(1'(fea_pkg::ACTION_FREE), 0, 32'hFFFF_FFFF);
      send_word(1'(fea_pkg::ACTION_ALLOC), 0, 32'hFFFF_FFFF);
      send_word(1'(fea_pkg::ACTION_FREE), 32'h8000_0000, 32'h8000_0000);
      send_word(1'(fea_pkg::ACTION_FREE), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(1'(fea_pkg::ACTION_ALLOC), 0, 32'h8000_0000);

      // fill the table so the full case shows up, with a long receiver stall
      drain();
      long_hold = 1;
      for (int k = 0; k < 34; k++)
         send_word(1'(fea_pkg::ACTION_FREE), 32'(32'h100 * k + 32'h10000), 32'd8);
      drain();

      // policies cycle through first, best, next, unused code, then best and next again
      for (int ph = 0; ph < 6; ph++) begin
         set_policy(ph == 3 ? 2'd3 : 2'(ph % 3));
         if (ph == 2) begin
            send_word(1'(fea_pkg::ACTION_ALLOC), 0, 1);
            send_word(1'(fea_pkg::ACTION_ALLOC), 0, 1);
         end
         for (int n = 0; n < 250; ) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && n < 250; b++, n++) random_word();
            if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 12));
            if (n > 125 && n < 146 && ph == 1) long_hold = 1;
         end
         // after each phase, trim the table to keep it from saturating
         drain();
         for (int n = 0; n < 40 && ledger.ext_cnt > 4; n++)
            send_word(1'(fea_pkg::ACTION_ALLOC), 0, 1);
      end

      drain();
      if (ledger.errors == 0 && ledger.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
